@@ design/mbc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mbc_pkg;

	localparam int RefW = 10;
	localparam int QUARTER_TURN_STEPS = 50;
	localparam int COUNT_BITS = 8;
	localparam int StepsW = 7;
	localparam int ReportW = 8;
	localparam int NumBins = 4;

	localparam int StepsMax = (1 << StepsW) - 1;
	localparam int HalfRaw = 2 * QUARTER_TURN_STEPS;
	localparam logic [StepsW-1:0] QuarterSteps =
		StepsW'((QUARTER_TURN_STEPS > StepsMax) ? StepsMax : QUARTER_TURN_STEPS);
	localparam logic [StepsW-1:0] HalfSteps =
		StepsW'((HalfRaw > StepsMax) ? StepsMax : HalfRaw);
	localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

	localparam int InDataW = 16;
	localparam int OutFieldsW = 3 + StepsW + 1 + NumBins * ReportW;
	localparam int OutDataW = ((OutFieldsW + 7) / 8) * 8;

	typedef enum logic [1:0] {
		CFG_ALU_LOW   = 2'd0,
		CFG_ALU_HIGH  = 2'd1,
		CFG_STEEL_HIGH = 2'd2,
		CFG_WHITE_HIGH = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		BIN_BLACK = 3'd0,
		BIN_STEEL = 3'd1,
		BIN_WHITE = 3'd2,
		BIN_ALU   = 3'd3,
		BIN_NONE  = 3'd4
	} bin_t;

	typedef struct packed {
		logic [RefW-1:0] alu_low;
		logic [RefW-1:0] alu_high;
		logic [RefW-1:0] steel_high;
		logic [RefW-1:0] white_high;
	} limits_t;

	typedef struct packed {
		logic [ReportW-1:0] alu;
		logic [ReportW-1:0] white;
		logic [ReportW-1:0] steel;
		logic [ReportW-1:0] black;
	} counts_t;

	typedef struct packed {
		counts_t           counts;
		logic              rotate_forward;
		logic [StepsW-1:0] rotate_steps;
		bin_t              bin_class;
	} result_t;

	function automatic logic [ReportW-1:0] cnt_report(input logic [COUNT_BITS-1:0] cnt);
		logic [COUNT_BITS+ReportW-1:0] wide;
		wide = {{ReportW{1'b0}}, cnt};
		return wide[ReportW-1:0];
	endfunction

endpackage

`default_nettype wire

@@ design/material_bin_classifier_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sorts one piece per transfer into a bin from its reflectance and magnetic flag, and
// reports the bin, the tray turn and the four saturating bin counts. The block takes
// one piece every clock cycle unless back-pressure holds it; a piece passes through the
// input register and then the result register, which drives m_tdata. The tray position
// and counts update as a piece leaves the input register. Back-pressure on the result
// side stalls the input register only once the result register is full. The user must
// see that the limits are written through cfg_we, cfg_index and cfg_data only while no
// piece is in flight; the block itself does not enforce this.

module material_bin_classifier_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [mbc_pkg::RefW-1:0]     cfg_data,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [mbc_pkg::InDataW-1:0]  s_tdata,   // reflectance, zero fill
	input  wire logic                         s_tuser,   // is_magnetic
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// bin_class, rotate_steps, rotate_forward, black_count, steel_count,
	// white_count, aluminium_count, zero fill
	output logic [mbc_pkg::OutDataW-1:0]      m_tdata
);
	import mbc_pkg::*;

	limits_t         limits_q;
	logic            valid_s1;
	logic [RefW-1:0] refl_s1;
	logic            mag_s1;
	logic            valid_s2;
	result_t         result_s2;
	logic            out_free;
	logic            advance;
	bin_t            bin_class;
	result_t         result;

	assign out_free = !valid_s2 || m_tready;
	assign advance = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.alu_low <= RefW'(1);
			limits_q.alu_high <= RefW'(322);
			limits_q.steel_high <= RefW'(802);
			limits_q.white_high <= RefW'(888);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ALU_LOW:    limits_q.alu_low <= cfg_data;
				CFG_ALU_HIGH:   limits_q.alu_high <= cfg_data;
				CFG_STEEL_HIGH: limits_q.steel_high <= cfg_data;
				CFG_WHITE_HIGH: limits_q.white_high <= cfg_data;
				default:        limits_q <= limits_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			refl_s1 <= s_tdata[RefW-1:0];
			mag_s1 <= s_tuser;
		end
	end

	mbc_classify u_classify (
		.reflectance (refl_s1),
		.is_magnetic (mag_s1),
		.limits      (limits_q),
		.bin_class   (bin_class)
	);

	mbc_tray u_tray (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.bin_class (bin_class),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {{(OutDataW - OutFieldsW){1'b0}}, result_s2};

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(refl_s1) && $stable(mag_s1)))
		else $error("stalled piece lost from the input register");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_free |-> s_tready)
		else $error("input stalled while the result register can take a piece");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("sorted piece did not reach the result register");

endmodule

`default_nettype wire

@@ design/mbc_classify.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mbc_classify (
	input  wire logic [mbc_pkg::RefW-1:0] reflectance,
	input  wire logic                     is_magnetic,
	input  wire mbc_pkg::limits_t         limits,
	output mbc_pkg::bin_t                 bin_class
);
	import mbc_pkg::*;

	always_comb begin
		priority if (is_magnetic) begin
			bin_class = (reflectance > limits.alu_high) ? BIN_STEEL : BIN_ALU;
		end else if (reflectance > limits.white_high) begin
			bin_class = BIN_BLACK;
		end else if (reflectance > limits.steel_high) begin
			bin_class = BIN_WHITE;
		end else if (reflectance > limits.alu_high) begin
			bin_class = BIN_STEEL;
		end else if (reflectance > limits.alu_low) begin
			bin_class = BIN_ALU;
		end else begin
			bin_class = BIN_NONE;
		end
	end

endmodule

`default_nettype wire

@@ design/mbc_tray.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mbc_tray (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            advance,
	input  wire mbc_pkg::bin_t   bin_class,
	output mbc_pkg::result_t     result
);
	import mbc_pkg::*;

	logic [1:0]            tray_q;
	logic [COUNT_BITS-1:0] cnt_q   [NumBins];
	logic [COUNT_BITS-1:0] cnt_nxt [NumBins];
	logic                  classified;
	logic [1:0]            bin_idx;
	logic [1:0]            offset;

	assign classified = (bin_class != BIN_NONE);
	assign bin_idx = bin_class[1:0];
	assign offset = tray_q - bin_idx;

	always_comb begin
		for (int i = 0; i < NumBins; i++) begin
			if (classified && (bin_idx == 2'(i)) && (cnt_q[i] != CountMax)) begin
				cnt_nxt[i] = cnt_q[i] + 1'b1;
			end else begin
				cnt_nxt[i] = cnt_q[i];
			end
		end
	end

	always_comb begin
		result.bin_class = bin_class;
		result.rotate_steps = '0;
		result.rotate_forward = 1'b0;
		if (classified) begin
			unique case (offset)
				2'd0: begin
					result.rotate_steps = '0;
				end
				2'd1: begin
					result.rotate_steps = QuarterSteps;
					result.rotate_forward = 1'b1;
				end
				2'd2: begin
					result.rotate_steps = HalfSteps;
				end
				2'd3: begin
					result.rotate_steps = QuarterSteps;
				end
				default: begin
					result.rotate_steps = '0;
				end
			endcase
		end
		result.counts.black = cnt_report(cnt_nxt[2'(BIN_BLACK)]);
		result.counts.steel = cnt_report(cnt_nxt[2'(BIN_STEEL)]);
		result.counts.white = cnt_report(cnt_nxt[2'(BIN_WHITE)]);
		result.counts.alu = cnt_report(cnt_nxt[2'(BIN_ALU)]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tray_q <= 2'd0;
			for (int i = 0; i < NumBins; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (advance) begin
			if (classified) begin
				tray_q <= bin_idx;
			end
			for (int i = 0; i < NumBins; i++) begin
				cnt_q[i] <= cnt_nxt[i];
			end
		end
	end

	// The tray only moves when a piece is sorted into a bin.
	a_tray_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && classified) |=> $stable(tray_q))
		else $error("tray position changed without a classified piece");

	a_none_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !classified) |=> ($stable(cnt_q[0]) && $stable(cnt_q[1]) &&
			$stable(cnt_q[2]) && $stable(cnt_q[3])))
		else $error("counts changed for an unclassified piece");

	a_tray_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && classified) |=> (tray_q == $past(bin_idx)))
		else $error("tray position does not match the last bin");

	a_count_rises: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && classified) |=> (cnt_q[$past(bin_idx)] >= $past(cnt_q[bin_idx])))
		else $error("bin count decreased");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import mbc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 60;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [RefW-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [InDataW-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OutDataW-1:0] m_tdata;

	limits_t limits;
	logic [1:0] tray_pos;
	logic [COUNT_BITS-1:0] bin_tally [NumBins];
	result_t pending_results [$];

	int errors = 0;
	int cycles = 0;
	bit src_idle = 1'b1;
	bit sink_stall = 1'b1;
	bit hold_req = 1'b0;

	material_bin_classifier_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic result_t sort_piece(input logic [RefW-1:0] refl, input logic magnetic);
		bin_t bin;
		logic [1:0] offset;
		result_t res;
		if (magnetic) begin
			bin = (refl > limits.alu_high) ? BIN_STEEL : BIN_ALU;
		end else if (refl > limits.white_high) begin
			bin = BIN_BLACK;
		end else if (refl > limits.steel_high) begin
			bin = BIN_WHITE;
		end else if (refl > limits.alu_high) begin
			bin = BIN_STEEL;
		end else if (refl > limits.alu_low) begin
			bin = BIN_ALU;
		end else begin
			bin = BIN_NONE;
		end
		res = '0;
		res.bin_class = bin;
		if (bin != BIN_NONE) begin
			offset = tray_pos - bin[1:0];
			case (offset)
				2'd1: begin
					res.rotate_steps = QuarterSteps;
					res.rotate_forward = 1'b1;
				end
				2'd2: begin
					res.rotate_steps = HalfSteps;
				end
				2'd3: begin
					res.rotate_steps = QuarterSteps;
				end
				default: begin
				end
			endcase
			tray_pos = bin[1:0];
			if (bin_tally[bin[1:0]] != CountMax)
				bin_tally[bin[1:0]] = bin_tally[bin[1:0]] + 1'b1;
		end
		res.counts.black = ReportW'(bin_tally[2'(BIN_BLACK)]);
		res.counts.steel = ReportW'(bin_tally[2'(BIN_STEEL)]);
		res.counts.white = ReportW'(bin_tally[2'(BIN_WHITE)]);
		res.counts.alu = ReportW'(bin_tally[2'(BIN_ALU)]);
		return res;
	endfunction

	function automatic void compare_field(input string field, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endfunction

	// Readings are drawn either uniformly or right around one of the limits.
	function automatic logic [RefW-1:0] pick_reflectance();
		int base;
		int v;
		if ($urandom_range(1) == 0)
			return RefW'($urandom_range(1023));
		case ($urandom_range(3))
			0: base = limits.alu_low;
			1: base = limits.alu_high;
			2: base = limits.steel_high;
			default: base = limits.white_high;
		endcase
		v = base + int'($urandom_range(2)) - 1;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return RefW'(v);
	endfunction

	task automatic send_piece(input logic [RefW-1:0] refl, input logic magnetic);
		while (src_idle && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= InDataW'(refl);
		s_tuser <= magnetic;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(sort_piece(refl, magnetic));
	endtask

	task automatic send_random(input int count);
		repeat (count) send_piece(pick_reflectance(), 1'($urandom_range(1)));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limits(input limits_t lim);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ALU_LOW;
		cfg_data <= lim.alu_low;
		@(posedge clk);
		cfg_index <= CFG_ALU_HIGH;
		cfg_data <= lim.alu_high;
		@(posedge clk);
		cfg_index <= CFG_STEEL_HIGH;
		cfg_data <= lim.steel_high;
		@(posedge clk);
		cfg_index <= CFG_WHITE_HIGH;
		cfg_data <= lim.white_high;
		@(posedge clk);
		cfg_we <= 1'b0;
		limits = lim;
		@(posedge clk);
	endtask

	task automatic run_limit_phase(input limits_t lim, input int count);
		set_limits(lim);
		send_random(count);
		wait_drained();
	endtask

	task automatic test_directed();
		send_piece(10'd1023, 1'b0);
		send_piece(10'd889, 1'b0);
		send_piece(10'd888, 1'b0);
		send_piece(10'd802, 1'b0);
		send_piece(10'd322, 1'b0);
		send_piece(10'd1, 1'b0);
		send_piece(10'd1023, 1'b0);
		send_piece(10'd0, 1'b1);
		send_piece(10'd0, 1'b0);
		send_piece(10'd803, 1'b0);
		send_piece(10'd323, 1'b0);
		send_piece(10'd2, 1'b0);
		send_piece(10'd322, 1'b1);
		send_piece(10'd323, 1'b1);
		send_piece(10'd1023, 1'b1);
		send_piece(10'h2AA, 1'b0);
		send_piece(10'h155, 1'b1);
		send_piece(10'h155, 1'b0);
		send_piece(10'h2AA, 1'b1);
		send_piece(10'd900, 1'b0);
		send_piece(10'd500, 1'b0);
		send_piece(10'd100, 1'b0);
		send_piece(10'd850, 1'b0);
		send_piece(10'd1, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_defaults();
		send_random(40);
		wait_drained();
	endtask

	task automatic test_limit_settings();
		limits_t lim;
		lim.alu_low = RefW'($urandom_range(0, 200));
		lim.alu_high = RefW'($urandom_range(201, 500));
		lim.steel_high = RefW'($urandom_range(501, 800));
		lim.white_high = RefW'($urandom_range(801, 1023));
		run_limit_phase(lim, 20);
		run_limit_phase('0, 20);
		run_limit_phase('1, 20);
		// Limits in reverse order: the compares still run in their fixed order.
		lim.alu_low = 10'd1000;
		lim.alu_high = 10'd900;
		lim.steel_high = 10'd500;
		lim.white_high = 10'd100;
		run_limit_phase(lim, 20);
		lim.alu_low = RefW'($urandom_range(1023));
		lim.alu_high = RefW'($urandom_range(1023));
		lim.steel_high = RefW'($urandom_range(1023));
		lim.white_high = RefW'($urandom_range(1023));
		run_limit_phase(lim, 20);
	endtask

	task automatic test_backpressure();
		src_idle = 1'b0;
		hold_req = 1'b1;
		send_random(30);
		wait_drained();
		src_idle = 1'b1;
	endtask

	task automatic test_count_saturation();
		limits_t lim;
		int extra;
		lim.alu_low = 10'd1;
		lim.alu_high = 10'd322;
		lim.steel_high = 10'd802;
		lim.white_high = 10'd888;
		set_limits(lim);
		src_idle = 1'b0;
		sink_stall = 1'b0;
		extra = 0;
		while (bin_tally[2'(BIN_BLACK)] != CountMax || extra < 20) begin
			if (bin_tally[2'(BIN_BLACK)] == CountMax)
				extra++;
			if ($urandom_range(99) < 90)
				send_piece(RefW'($urandom_range(limits.white_high + 1, 1023)), 1'b0);
			else
				send_piece(pick_reflectance(), 1'($urandom_range(1)));
			if (extra == 10) begin
				src_idle = 1'b1;
				sink_stall = 1'b1;
			end
		end
		wait_drained();
		src_idle = 1'b1;
		sink_stall = 1'b1;
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= !(sink_stall && $urandom_range(99) < 15);
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[$bits(result_t)-1:0]);
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result transfer with nothing expected, actual %h", $time, m_tdata);
			end else begin
				want = pending_results.pop_front();
				compare_field("bin_class", want.bin_class, got.bin_class);
				compare_field("rotate_steps", want.rotate_steps, got.rotate_steps);
				compare_field("rotate_forward", want.rotate_forward, got.rotate_forward);
				compare_field("black_count", want.counts.black, got.counts.black);
				compare_field("steel_count", want.counts.steel, got.counts.steel);
				compare_field("white_count", want.counts.white, got.counts.white);
				compare_field("aluminium_count", want.counts.alu, got.counts.alu);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ALU_LOW;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		limits.alu_low = 10'd1;
		limits.alu_high = 10'd322;
		limits.steel_high = 10'd802;
		limits.white_high = 10'd888;
		tray_pos = '0;
		foreach (bin_tally[i])
			bin_tally[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_defaults();
		test_limit_settings();
		test_backpressure();
		test_count_saturation();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
design/mbc_pkg.sv
design/mbc_classify.sv
design/mbc_tray.sv
design/material_bin_classifier_top.sv
tb/tb.sv
